// File: src/btrl_pkg.sv
package btrl_pkg;

	localparam int IFACE_W = 8;
	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 6;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

endpackage

// File: src/binary_trie_route_lookup_core.sv
// Longest-prefix-match engine for IPv4 routes on a one-bit binary trie. An item is
// taken on a clock edge with start high and busy low; func selects insert (store
// route_interface under the first prefix_len bits of address, prefix_len above
// ADDR_BITS counting as ADDR_BITS) or lookup (answer the interface of the longest
// stored prefix of address, 0 when none, the length-0 route acting as default).
// Each item yields exactly one result, shown for a single cycle with done high;
// the receiver cannot stall it, so it must take every transfer as it comes. Timing:
// the walk visits one trie level per cycle, bounded by the node memory's single
// read per cycle; an insert of effective length L descends up to L levels, a
// lookup at most ADDR_BITS (32 for IPv4), ending early at a missing link. The
// done strobe coincides with busy falling, so the next start may be accepted in
// that same cycle. Node memory holds NODES entries, of which index 0 is never
// used (the root lives in flip-flops); once NODES-1 nodes are handed out, an
// insert needing a further node ends with status 1 and stores no route, leaving
// any nodes it already added in place. There is no clearing pass after reset:
// nodes are written when allocated.
module binary_trie_route_lookup_core
	import btrl_pkg::*;
#(
	parameter int NODES     = 4096,
	parameter int ADDR_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [ADDR_W-1:0]  address,
	input  logic [LEN_W-1:0]   prefix_len,
	input  logic [IFACE_W-1:0] route_interface,
	output logic               done,
	output logic [IFACE_W-1:0] out_interface,
	output logic               status
);

	localparam int IDX_W   = $clog2(NODES);
	localparam int D_W     = $clog2(ADDR_BITS + 1);
	localparam int ENTRY_W = 2 * IDX_W + 1 + IFACE_W;

	localparam logic [IDX_W:0] NODES_C    = (IDX_W + 1)'(NODES);
	localparam logic [D_W-1:0] DEPTH_MAX  = D_W'(ADDR_BITS);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(ADDR_BITS);

	// one trie node: child links (0 = none), route mark and interface
	typedef struct packed {
		logic [IDX_W-1:0]   left;
		logic [IDX_W-1:0]   right;
		logic               valid;
		logic [IFACE_W-1:0] iface;
	} node_t;

	state_t state_q;

	node_t                root_q;        // root entry, length-0 route
	logic [IDX_W:0]       next_free_q;   // bump allocator, holds NODES when exhausted

	// walk context
	node_t                cur_q;         // current node when not just read from memory
	logic                 from_mem_q;    // current node is in the RAM read register
	logic [IDX_W-1:0]     cur_idx_q;     // index of current node, 0 = root
	logic [ADDR_BITS-1:0] addr_q;        // remaining address bits, next one at MSB
	logic [D_W-1:0]       d_q;           // depth reached
	logic [D_W-1:0]       lim_q;         // depth at which the walk ends
	logic                 func_q;
	logic [IFACE_W-1:0]   iface_q;
	logic [IFACE_W-1:0]   best_q;        // deepest marked interface so far

	logic                 done_q;
	logic [IFACE_W-1:0]   out_iface_q;
	logic                 status_q;

	// memory port
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [ENTRY_W-1:0]   mem_wdata;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_raddr;
	logic [ENTRY_W-1:0]   mem_rdata;

	// walk decode
	logic                 accept;
	logic                 walking;
	logic                 is_insert;
	node_t                cur;
	logic                 dir;
	logic [IDX_W-1:0]     link;
	logic                 at_end;
	logic                 link_nil;
	logic                 full;
	logic [IDX_W-1:0]     nf_idx;
	logic [IFACE_W-1:0]   best_n;
	node_t                alloc_node;
	node_t                mark_node;
	node_t                wb_node;
	logic                 wb_en;
	logic                 step_read;
	logic                 step_alloc;
	logic                 finish;
	logic [LEN_W-1:0]     len_clip;

	assign accept    = start && !busy;
	assign walking   = (state_q == ST_WALK);
	assign is_insert = (func_q == FUNC_INSERT);

	assign cur      = from_mem_q ? node_t'(mem_rdata) : cur_q;
	assign dir      = addr_q[ADDR_BITS-1];
	assign link     = dir ? cur.right : cur.left;
	assign at_end   = (d_q == lim_q);
	assign link_nil = (link == '0);
	assign full     = (next_free_q >= NODES_C);
	assign nf_idx   = next_free_q[IDX_W-1:0];
	assign best_n   = cur.valid ? cur.iface : best_q;

	always_comb begin
		alloc_node = cur;
		if (dir) begin
			alloc_node.right = nf_idx;
		end else begin
			alloc_node.left = nf_idx;
		end
		mark_node       = cur;
		mark_node.valid = 1'b1;
		mark_node.iface = iface_q;
	end

	// Insert: the current node is written back when the walk leaves it through a
	// new link, and at the end (marked, or unchanged on a full stop so that a node
	// just allocated lands in memory cleared). Following an existing link needs no
	// write. A read never targets the entry written in the same cycle, so the RAM
	// needs no bypass.
	always_comb begin
		step_read  = 1'b0;
		step_alloc = 1'b0;
		finish     = 1'b0;
		wb_en      = 1'b0;
		if (walking) begin
			if (is_insert) begin
				wb_en      = at_end || link_nil;
				step_read  = !at_end && !link_nil;
				step_alloc = !at_end && link_nil && !full;
				finish     = at_end || (link_nil && full);
			end else begin
				step_read  = !at_end && !link_nil;
				finish     = at_end || link_nil;
			end
		end
	end

	always_comb begin
		priority if (at_end) begin
			wb_node = mark_node;
		end else if (full) begin
			wb_node = cur;
		end else begin
			wb_node = alloc_node;
		end
	end

	assign mem_we    = wb_en && (cur_idx_q != '0);
	assign mem_waddr = cur_idx_q;
	assign mem_wdata = ENTRY_W'(wb_node);
	assign mem_re    = step_read;
	assign mem_raddr = link;

	assign len_clip = (prefix_len > LEN_MAX) ? LEN_MAX : prefix_len;

	btrl_node_ram #(
		.DEPTH (NODES),
		.WIDTH (ENTRY_W)
	) u_node_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			next_free_q <= (IDX_W + 1)'(1);
			root_q      <= '0;
		end else begin
			done_q <= finish;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (step_alloc) begin
				next_free_q <= next_free_q + (IDX_W + 1)'(1);
			end
			if (wb_en && (cur_idx_q == '0)) begin
				root_q <= wb_node;
			end
		end
	end

	// walk context and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q      <= root_q;
			from_mem_q <= 1'b0;
			cur_idx_q  <= '0;
			addr_q     <= address[ADDR_BITS-1:0];
			d_q        <= '0;
			lim_q      <= (func == FUNC_INSERT) ? D_W'(len_clip) : DEPTH_MAX;
			func_q     <= func;
			iface_q    <= route_interface;
			best_q     <= '0;
		end else if (step_read || step_alloc) begin
			cur_q      <= '0;                 // fresh node on allocation
			from_mem_q <= step_read;
			cur_idx_q  <= step_read ? link : nf_idx;
			addr_q     <= {addr_q[ADDR_BITS-2:0], 1'b0};
			d_q        <= d_q + D_W'(1);
			best_q     <= best_n;
		end
		if (finish) begin
			out_iface_q <= is_insert ? '0 : best_n;
			status_q    <= (is_insert && !at_end) ? STATUS_FULL : STATUS_DONE;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign out_interface = out_iface_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while walk still running");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("node RAM read and write in one cycle");

	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= NODES_C)
		else $error("allocator beyond node memory");

	a_lookup_status: assert property (@(posedge clk) disable iff (!arst_n)
		finish && !is_insert |=> done && status == STATUS_DONE)
		else $error("lookup reported full");

	a_insert_iface: assert property (@(posedge clk) disable iff (!arst_n)
		finish && is_insert |=> done && out_interface == '0)
		else $error("insert returned an interface");
`endif

endmodule

// File: src/btrl_node_ram.sv
module btrl_node_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import btrl_pkg::*;

	localparam int NODE_COUNT    = 4096;
	localparam int TRIE_DEPTH    = 32;
	localparam int LINK_W        = $clog2(NODE_COUNT) + 1;
	localparam int CLK_HALF      = 6;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int DRAIN_LIMIT   = 400;
	// A lookup can walk all 32 levels plus the root, so allow a little over that.
	localparam int SETTLE_CYCLES = TRIE_DEPTH + 8;
	localparam int ROUTES_KEPT   = 600;
	// Phase-one inserts stop growing the trie once this little room is left.
	localparam int SPARE_NODES   = 700;

	typedef struct {
		logic [LINK_W-1:0]  left;
		logic [LINK_W-1:0]  right;
		logic               valid;
		logic [IFACE_W-1:0] iface;
	} trie_node_t;

	typedef struct packed {
		logic [IFACE_W-1:0] iface;
		logic               status;
	} route_answer_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               func;
	logic [ADDR_W-1:0]  address;
	logic [LEN_W-1:0]   prefix_len;
	logic [IFACE_W-1:0] route_interface;
	logic               done;
	logic [IFACE_W-1:0] out_interface;
	logic               status;

	// Mirror of the trie. Entry 0 stands for the root: link value 0 means
	// "no child", so no link can ever point back at it.
	trie_node_t    trie_mirror[NODE_COUNT];
	int unsigned   mirror_next_free;
	route_answer_t expected_answers[$];

	// Routes known to be stored, used to aim lookups and inserts at live paths.
	logic [ADDR_W-1:0] stored_prefix[$];
	int unsigned       stored_len[$];

	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left  = 0;

	binary_trie_route_lookup_core #(
		.NODES     (NODE_COUNT),
		.ADDR_BITS (TRIE_DEPTH)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.address         (address),
		.prefix_len      (prefix_len),
		.route_interface (route_interface),
		.done            (done),
		.out_interface   (out_interface),
		.status          (status)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// ---------------------------------------------------------------
	// Trie mirror
	// ---------------------------------------------------------------

	function automatic void mirror_reset();
		trie_mirror[0]   = '{left: '0, right: '0, valid: 1'b0, iface: '0};
		mirror_next_free = 1;
	endfunction

	function automatic int unsigned clamp_len(input int unsigned len);
		return (len > TRIE_DEPTH) ? TRIE_DEPTH : len;
	endfunction

	function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
		if (len >= TRIE_DEPTH)
			return '1;
		return ~({ADDR_W{1'b1}} >> len);
	endfunction

	// Insert: walk the leading bits, growing missing nodes from the bump
	// counter. Running out mid-path leaves the new nodes behind, unrouted.
	function automatic route_answer_t trie_insert(input logic [ADDR_W-1:0] prefix,
			input int unsigned len, input logic [IFACE_W-1:0] iface);
		int unsigned   depth;
		int unsigned   node;
		int unsigned   child;
		logic          go_right;
		route_answer_t ans;
		ans.iface  = '0;
		ans.status = STATUS_DONE;
		node       = 0;
		for (depth = 0; depth < clamp_len(len); depth++) begin
			go_right = prefix[TRIE_DEPTH-1-depth];
			child    = go_right ? 32'(trie_mirror[node].right)
				: 32'(trie_mirror[node].left);
			if (child == 0) begin
				if (mirror_next_free >= NODE_COUNT) begin
					ans.status = STATUS_FULL;
					return ans;
				end
				child = mirror_next_free;
				if (go_right)
					trie_mirror[node].right = LINK_W'(child);
				else
					trie_mirror[node].left = LINK_W'(child);
				trie_mirror[child] = '{left: '0, right: '0, valid: 1'b0, iface: '0};
				mirror_next_free++;
			end
			node = child;
		end
		trie_mirror[node].valid = 1'b1;
		trie_mirror[node].iface = iface;
		return ans;
	endfunction

	// Lookup: deepest marked node on the address's path, root included.
	function automatic route_answer_t trie_lookup(input logic [ADDR_W-1:0] addr);
		int unsigned   depth;
		int unsigned   node;
		route_answer_t ans;
		ans.iface  = '0;
		ans.status = STATUS_DONE;
		node       = 0;
		depth      = 0;
		forever begin
			if (trie_mirror[node].valid)
				ans.iface = trie_mirror[node].iface;
			if (depth >= TRIE_DEPTH)
				break;
			node = addr[TRIE_DEPTH-1-depth] ? 32'(trie_mirror[node].right)
				: 32'(trie_mirror[node].left);
			if (node == 0)
				break;
			depth++;
		end
		return ans;
	endfunction

	function automatic void remember_route(input logic [ADDR_W-1:0] prefix,
			input int unsigned len);
		int unsigned slot;
		if (stored_prefix.size() < ROUTES_KEPT) begin
			stored_prefix.push_back(prefix);
			stored_len.push_back(clamp_len(len));
		end else begin
			slot                = $urandom_range(0, ROUTES_KEPT - 1);
			stored_prefix[slot] = prefix;
			stored_len[slot]    = clamp_len(len);
		end
	endfunction

	// ---------------------------------------------------------------
	// Sender: one item per call. Start stays high between back-to-back
	// items and only drops when a gap is drawn.
	// ---------------------------------------------------------------

	task automatic send_item(input logic f, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len, input logic [IFACE_W-1:0] iface);
		int unsigned   gap;
		route_answer_t ans;
		if (burst_left != 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(10, 40);
		end
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start           <= 1'b1;
		func            <= f;
		address         <= addr;
		prefix_len      <= len;
		route_interface <= iface;
		// Transfer happens on the first rising edge that sees busy low.
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (f == FUNC_INSERT)
			ans = trie_insert(addr, 32'(len), iface);
		else
			ans = trie_lookup(addr);
		expected_answers.push_back(ans);
		if (f == FUNC_INSERT && ans.status == STATUS_DONE)
			remember_route(addr, 32'(len));
	endtask

	// ---------------------------------------------------------------
	// Result checker: every done cycle is a transfer.
	// ---------------------------------------------------------------

	always @(posedge clk) begin : check_answers
		route_answer_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected result: out_interface %0d status %0d",
					out_interface, status);
				fail_count++;
			end else begin
				want = expected_answers.pop_front();
				if (out_interface !== want.iface) begin
					$error("out_interface: expected %0d, got %0d", want.iface, out_interface);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** binary_trie_route_lookup_core: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Random item makers
	// ---------------------------------------------------------------

	// Mostly aimed under a stored prefix with random tail bits, so the walk
	// goes deep; the rest are plain random addresses.
	task automatic random_lookup();
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] keep;
		int unsigned       pick;
		addr = $urandom();
		if (stored_prefix.size() != 0 && $urandom_range(0, 9) < 7) begin
			pick = $urandom_range(0, stored_prefix.size() - 1);
			keep = prefix_mask(stored_len[pick]);
			addr = (stored_prefix[pick] & keep) | (addr & ~keep);
		end
		// prefix_len and route_interface are don't-care on a lookup
		send_item(FUNC_LOOKUP, addr, LEN_W'($urandom()), IFACE_W'($urandom()));
	endtask

	// Extend a stored route, re-mark a node on its path, overwrite it, or
	// start a fresh one. With conserve set only the non-growing kinds are used.
	task automatic random_insert(input bit conserve);
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] keep;
		int unsigned       pick;
		int unsigned       kind;
		int unsigned       len;
		addr = $urandom();
		kind = conserve ? $urandom_range(40, 79) : $urandom_range(0, 99);
		len  = $urandom_range(0, 16);
		if (stored_prefix.size() != 0 && kind < 80) begin
			pick = $urandom_range(0, stored_prefix.size() - 1);
			keep = prefix_mask(stored_len[pick]);
			addr = (stored_prefix[pick] & keep) | (addr & ~keep);
			if (kind < 40)
				len = clamp_len(stored_len[pick] + $urandom_range(1, 8));
			else if (kind < 65)
				len = $urandom_range(0, stored_len[pick]);
			else
				len = stored_len[pick];
		end else if (kind >= 95) begin
			// long and overlong prefixes, up to the field's top value
			len = $urandom_range(17, 63);
		end
		send_item(FUNC_INSERT, addr, LEN_W'(len), IFACE_W'($urandom()));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_empty_trie();
		send_item(FUNC_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF);
	endtask

	// Length-0 route marks the root; address bits are irrelevant to it.
	task automatic test_default_route();
		send_item(FUNC_INSERT, 32'hDEAD_BEEF, 6'd0, 8'hA5);
		send_item(FUNC_LOOKUP, 32'h5A5A_0F0F, 6'd17, 8'h11);
		send_item(FUNC_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
	endtask

	task automatic test_address_extremes();
		send_item(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF);
		send_item(FUNC_INSERT, 32'h0000_0000, 6'd32, 8'h01);
		send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'h8000_0000, 6'd0, 8'h00);
	endtask

	// Lengths above 32 act as a host route.
	task automatic test_overlong_prefix();
		send_item(FUNC_INSERT, 32'h1234_5678, 6'd63, 8'h3C);
		send_item(FUNC_INSERT, 32'h1234_5679, 6'd33, 8'h3D);
		send_item(FUNC_LOOKUP, 32'h1234_5678, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'h1234_5679, 6'd0, 8'h00);
	endtask

	// Re-insert replaces the interface; deeper routes win; interface 0 is
	// still a route and hides shorter matches.
	task automatic test_overwrite_and_nesting();
		send_item(FUNC_INSERT, 32'h0A00_0000, 6'd8, 8'h10);
		send_item(FUNC_INSERT, 32'h0AFF_FFFF, 6'd8, 8'h20);
		send_item(FUNC_INSERT, 32'h0A01_0000, 6'd16, 8'h30);
		send_item(FUNC_INSERT, 32'h0A01_00FF, 6'd24, 8'h00);
		send_item(FUNC_LOOKUP, 32'h0A12_3456, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'h0A01_FFFF, 6'd0, 8'h00);
		send_item(FUNC_LOOKUP, 32'h0A01_0005, 6'd0, 8'h00);
	endtask

	task automatic test_random_routes(input int unsigned count, input bit guard_room);
		repeat (count) begin
			if ($urandom_range(0, 99) < 55)
				random_lookup();
			else
				random_insert(guard_room && mirror_next_free + SPARE_NODES > NODE_COUNT);
		end
	endtask

	// Host routes on random addresses until the node store runs dry; the
	// crossing insert usually stops part way down its path.
	task automatic test_memory_full();
		int unsigned       tries;
		logic [ADDR_W-1:0] refused;
		tries   = 0;
		refused = '0;
		while (mirror_next_free < NODE_COUNT && tries < 400) begin
			send_item(FUNC_INSERT, $urandom(), 6'd32, IFACE_W'($urandom()));
			tries++;
		end
		repeat (3) begin
			refused = $urandom();
			send_item(FUNC_INSERT, refused, 6'd32, IFACE_W'($urandom()));
		end
		send_item(FUNC_LOOKUP, refused, 6'd0, 8'h00);
	endtask

	// With the store full, what needs no new node works; a growing insert fails.
	task automatic test_after_full();
		int unsigned       pick;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(0, stored_prefix.size() - 1);
		addr = stored_prefix[pick];
		send_item(FUNC_INSERT, addr, LEN_W'(stored_len[pick]), 8'h7E);
		send_item(FUNC_LOOKUP, addr, 6'd0, 8'h00);
		// node at depth 20 on the path of the last stored-route entry
		addr = stored_prefix[stored_prefix.size() - 1];
		send_item(FUNC_INSERT, addr, 6'd20, 8'h81);
		send_item(FUNC_LOOKUP, addr ^ 32'h0000_0F00, 6'd0, 8'h00);
		send_item(FUNC_INSERT, $urandom(), 6'd0, 8'h5C);
		send_item(FUNC_LOOKUP, $urandom(), 6'd0, 8'h00);
		send_item(FUNC_INSERT, $urandom(), 6'd40, 8'hC3);
	endtask

	initial begin : run
		int unsigned drain;
		arst_n          = 1'b0;
		start           = 1'b0;
		func            = FUNC_INSERT;
		address         = '0;
		prefix_len      = '0;
		route_interface = '0;
		mirror_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_trie();
		test_default_route();
		test_address_extremes();
		test_overlong_prefix();
		test_overwrite_and_nesting();
		test_random_routes(1000, 1'b1);
		test_memory_full();
		test_after_full();
		test_random_routes(650, 1'b0);

		@(negedge clk);
		start <= 1'b0;

		drain = 0;
		while (expected_answers.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_answers.size() != 0) begin
			$error("%0d results never arrived", expected_answers.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("** binary_trie_route_lookup_core: PASSED **");
		else
			$display("** binary_trie_route_lookup_core: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
src/btrl_pkg.sv
src/btrl_node_ram.sv
src/binary_trie_route_lookup_core.sv
tb/sv/testbench.sv
